/* rtl/tvss_pkg.sv */
// Package: widths, command codes and the control store of the two value span sequencer.
package tvss_pkg;

  // Field widths
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned MAX_LEN = 64;

  // Spread modes
  localparam logic [CMD_W-1:0] CMD_A_FIRST = 2'd0;
  localparam logic [CMD_W-1:0] CMD_B_FIRST = 2'd1;
  localparam logic [CMD_W-1:0] CMD_EVEN    = 2'd2;
  localparam logic [CMD_W-1:0] CMD_RSVD    = 2'd3;

  // Program counter and step addresses
  localparam int unsigned STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_WAIT  = 3'd0;
  localparam logic [STEP_W-1:0] STEP_CHECK = 3'd1;
  localparam logic [STEP_W-1:0] STEP_ROUTE = 3'd2;
  localparam logic [STEP_W-1:0] STEP_DIV   = 3'd3;
  localparam logic [STEP_W-1:0] STEP_EMIT  = 3'd4;
  localparam logic [STEP_W-1:0] STEP_DONE  = 3'd5;

  // Divider iterations: one quotient bit per step
  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(CNT_W - 1);

  // Datapath operations
  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_LOAD  = 3'd1,
    OP_SETUP = 3'd2,
    OP_DIV   = 3'd3,
    OP_EMIT  = 3'd4
  } op_t;

  // Jump conditions: jump to target when true, else fall through
  typedef enum logic [2:0] {
    CND_ALWAYS    = 3'd0,
    CND_NOT_ACC   = 3'd1,
    CND_BAD       = 3'd2,
    CND_NO_DIV    = 3'd3,
    CND_DIV_MORE  = 3'd4,
    CND_EMIT_MORE = 3'd5
  } cond_t;

  typedef struct packed {
    op_t               op;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  // Control store
  function automatic ctrl_t ucode_rom(input logic [STEP_W-1:0] addr);
    ctrl_t w;
    case (addr)
      STEP_WAIT:  w = '{op: OP_LOAD,  cond: CND_NOT_ACC,   target: STEP_WAIT};
      STEP_CHECK: w = '{op: OP_SETUP, cond: CND_BAD,       target: STEP_WAIT};
      STEP_ROUTE: w = '{op: OP_NONE,  cond: CND_NO_DIV,    target: STEP_EMIT};
      STEP_DIV:   w = '{op: OP_DIV,   cond: CND_DIV_MORE,  target: STEP_DIV};
      STEP_EMIT:  w = '{op: OP_EMIT,  cond: CND_EMIT_MORE, target: STEP_EMIT};
      STEP_DONE:  w = '{op: OP_NONE,  cond: CND_ALWAYS,    target: STEP_WAIT};
      default:    w = '{op: OP_NONE,  cond: CND_ALWAYS,    target: STEP_WAIT};
    endcase
    return w;
  endfunction

endpackage

/* rtl/two_value_span_sequencer.sv */
// Two value span sequencer: microcoded control, divider and byte emitter.
//
// Usage: one request beat on the in_ channel names two byte values, their
// counts, a total length and a spread mode. The block answers with
// total_length beats on the out_ channel, one byte each, with out_last set
// on the final beat. A request whose counts do not sum to the length, whose
// length is zero or above 64, or whose command is the reserved code yields
// no beats at all.
// Flow: an accepted request is checked and set up at the check step; even
// interleave with both counts nonzero then runs the one-bit-per-cycle
// divider to form the ratio before the emit step, while the other cases
// go straight to it. The program counter of the control store takes a new
// request only at its wait step, so no new request is taken until the
// previous one has been emitted or rejected.
// The result sits in an output register, so the next request is accepted
// while the last beat of the previous one still waits for the receiver.
// A receiver stall holds the output beat and freezes the emit step.
// Reset returns the program counter to the wait step and drops out_valid.
module two_value_span_sequencer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tvss_pkg::CMD_W-1:0]    in_command,
  input  logic [tvss_pkg::CNT_W-1:0]    in_count_a,
  input  logic [tvss_pkg::CNT_W-1:0]    in_count_b,
  input  logic [tvss_pkg::BYTE_W-1:0]   in_value_a,
  input  logic [tvss_pkg::BYTE_W-1:0]   in_value_b,
  input  logic [tvss_pkg::CNT_W-1:0]    in_total_length,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tvss_pkg::BYTE_W-1:0]   out_element,
  output logic                          out_last
);
  import tvss_pkg::*;

  // Control
  logic [STEP_W-1:0] pc_r, pc_nxt;
  ctrl_t             cw;
  logic              cond_hit;
  logic              in_acc;

  // Request registers
  logic [CMD_W-1:0]  cmd_r;
  logic [CNT_W-1:0]  ca_r, cb_r, len_r;
  logic [BYTE_W-1:0] va_r, vb_r;

  // Divider
  logic [CNT_W-1:0]  quo_r, quo_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  dvsr_r, dvsr_nxt;
  logic [STEP_W-1:0] dcnt_r, dcnt_nxt;
  logic [CNT_W:0]    rem_sh;
  logic [CNT_W:0]    rem_diff;

  // Sequence walk
  logic [CNT_W-1:0]  pos_r, pos_nxt;
  logic [CNT_W-1:0]  run_r, run_nxt;
  logic [CNT_W-1:0]  done_a_r, done_a_nxt;
  logic [CNT_W-1:0]  done_b_r, done_b_nxt;
  logic              on_b_r, on_b_nxt;
  logic [CNT_W-1:0]  pos_inc, run_inc;
  logic              beat_go, last_now, sel_b;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] elem_r, elem_nxt;
  logic              last_r, last_nxt;

  // Request checks
  logic              req_bad, no_div;
  logic [CNT_W:0]    cnt_sum;

  assign cw       = ucode_rom(pc_r);
  assign in_stall = (pc_r != STEP_WAIT);
  assign in_acc   = in_valid && !in_stall;

  assign cnt_sum = {1'b0, ca_r} + {1'b0, cb_r};
  assign req_bad = (cnt_sum != {1'b0, len_r}) || (len_r > CNT_W'(MAX_LEN))
                   || (len_r == '0) || (cmd_r == CMD_RSVD);
  assign no_div  = (cmd_r != CMD_EVEN) || (ca_r == '0) || (cb_r == '0);

  // Emit handshake and beat position
  assign beat_go  = (cw.op == OP_EMIT) && (!out_valid_r || !out_stall);
  assign pos_inc  = pos_r + CNT_W'(1);
  assign run_inc  = run_r + CNT_W'(1);
  assign last_now = (pos_inc == len_r);

  // Pick the value for the current slot
  always_comb begin
    case (cmd_r)
      CMD_A_FIRST: sel_b = (pos_r >= ca_r);
      CMD_B_FIRST: sel_b = (pos_r < cb_r);
      CMD_EVEN:    sel_b = no_div ? (ca_r == '0) : on_b_r;
      default:     sel_b = 1'b0;
    endcase
  end

  // Evaluate the jump condition
  always_comb begin
    case (cw.cond)
      CND_ALWAYS:    cond_hit = 1'b1;
      CND_NOT_ACC:   cond_hit = !in_acc;
      CND_BAD:       cond_hit = req_bad;
      CND_NO_DIV:    cond_hit = no_div;
      CND_DIV_MORE:  cond_hit = (dcnt_r != DIV_LAST);
      CND_EMIT_MORE: cond_hit = !(beat_go && last_now);
      default:       cond_hit = 1'b1;
    endcase
  end

  // Advance the program counter
  assign pc_nxt = cond_hit ? cw.target : pc_r + STEP_W'(1);

  // Divider step: shift in the next dividend bit, subtract when it fits
  assign rem_sh   = {rem_r, quo_r[CNT_W-1]};
  assign rem_diff = rem_sh - {1'b0, dvsr_r};

  // Datapath driven by the control word
  always_comb begin
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    dvsr_nxt      = dvsr_r;
    dcnt_nxt      = dcnt_r;
    pos_nxt       = pos_r;
    run_nxt       = run_r;
    done_a_nxt    = done_a_r;
    done_b_nxt    = done_b_r;
    on_b_nxt      = on_b_r;
    elem_nxt      = elem_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r;

    // Drop the output beat once taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (cw.op)
      OP_SETUP: begin
        on_b_nxt   = (cb_r >= ca_r);
        quo_nxt    = (cb_r >= ca_r) ? cb_r : ca_r;
        dvsr_nxt   = (cb_r >= ca_r) ? ca_r : cb_r;
        rem_nxt    = '0;
        dcnt_nxt   = '0;
        pos_nxt    = '0;
        run_nxt    = '0;
        done_a_nxt = '0;
        done_b_nxt = '0;
      end
      OP_DIV: begin
        if (!rem_diff[CNT_W]) begin
          rem_nxt = rem_diff[CNT_W-1:0];
          quo_nxt = {quo_r[CNT_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[CNT_W-1:0];
          quo_nxt = {quo_r[CNT_W-2:0], 1'b0};
        end
        dcnt_nxt = dcnt_r + STEP_W'(1);
      end
      OP_EMIT: begin
        if (beat_go) begin
          out_valid_nxt = 1'b1;
          elem_nxt      = sel_b ? vb_r : va_r;
          last_nxt      = last_now;
          pos_nxt       = pos_inc;
          run_nxt       = run_inc;
          if (on_b_r) begin
            done_b_nxt = done_b_r + CNT_W'(1);
          end else begin
            done_a_nxt = done_a_r + CNT_W'(1);
          end
          // Switch value after each full run while the other still has slots
          if (run_inc == quo_r) begin
            if (!on_b_r && (done_b_r < cb_r)) begin
              on_b_nxt = 1'b1;
            end else if (on_b_r && (done_a_r < ca_r)) begin
              on_b_nxt = 1'b0;
            end
            run_nxt = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= STEP_WAIT;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the request beat
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r <= in_command;
      ca_r  <= in_count_a;
      cb_r  <= in_count_b;
      va_r  <= in_value_a;
      vb_r  <= in_value_b;
      len_r <= in_total_length;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    quo_r    <= quo_nxt;
    rem_r    <= rem_nxt;
    dvsr_r   <= dvsr_nxt;
    dcnt_r   <= dcnt_nxt;
    pos_r    <= pos_nxt;
    run_r    <= run_nxt;
    done_a_r <= done_a_nxt;
    done_b_r <= done_b_nxt;
    on_b_r   <= on_b_nxt;
    elem_r   <= elem_nxt;
    last_r   <= last_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_element = elem_r;
  assign out_last    = last_r;

  // An accepted request is checked in the next cycle
  a_acc_to_check: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (pc_r == STEP_CHECK))
    else $error("request not followed by check step");

  // The divider never runs with a zero divisor
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == STEP_DIV) |-> (dvsr_r != '0))
    else $error("divide step with zero divisor");

  // Emission never runs past the requested length
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == STEP_EMIT) |-> (pos_r < len_r))
    else $error("emit position past length");

  // In interleave the run counter stays below the ratio
  a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ((pc_r == STEP_EMIT) && !no_div) |-> (run_r < quo_r))
    else $error("run counter reached ratio");

endmodule

/* bench/two_value_span_sequencer_chk.sv */
// Checker for the two value span sequencer: predicts each request's byte run and compares beats.
module two_value_span_sequencer_chk (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [tvss_pkg::CMD_W-1:0]    in_command,
  input  logic [tvss_pkg::CNT_W-1:0]    in_count_a,
  input  logic [tvss_pkg::CNT_W-1:0]    in_count_b,
  input  logic [tvss_pkg::BYTE_W-1:0]   in_value_a,
  input  logic [tvss_pkg::BYTE_W-1:0]   in_value_b,
  input  logic [tvss_pkg::CNT_W-1:0]    in_total_length,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [tvss_pkg::BYTE_W-1:0]   out_element,
  input  logic                          out_last,
  output int                            mismatches,
  output int                            beats_due
);
  timeunit 1ns;
  timeprecision 1ps;
  import tvss_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] element;
    logic              last;
  } span_beat_t;

  span_beat_t span_beats_q[$];
  span_beat_t want;
  int         errs = 0;

  // Queue the byte run that one request should produce
  function automatic void plan_span(input logic [CMD_W-1:0] command,
                                    input logic [CNT_W-1:0] count_a,
                                    input logic [CNT_W-1:0] count_b,
                                    input logic [BYTE_W-1:0] value_a,
                                    input logic [BYTE_W-1:0] value_b,
                                    input logic [CNT_W-1:0] span_len);
    int unsigned       sum;
    int unsigned       ratio;
    int unsigned       run;
    int unsigned       done_a;
    int unsigned       done_b;
    logic              on_b;
    logic [BYTE_W-1:0] pick;
    sum = count_a;
    sum = sum + count_b;
    // Drop requests whose counts do not add up, that run too long or use the spare code
    if (sum != span_len || span_len > MAX_LEN || command == CMD_RSVD) return;
    on_b = (count_b >= count_a);
    ratio = 0;
    if (count_a != 0 && count_b != 0) ratio = on_b ? count_b / count_a : count_a / count_b;
    run = 0;
    done_a = 0;
    done_b = 0;
    for (int unsigned i = 0; i < span_len; i++) begin
      case (command)
        CMD_A_FIRST: pick = (i < count_a) ? value_a : value_b;
        CMD_B_FIRST: pick = (i < count_b) ? value_b : value_a;
        default: begin
          if (ratio == 0) begin
            // One count is zero: fill with the other value
            pick = (count_a == 0) ? value_b : value_a;
          end else begin
            pick = on_b ? value_b : value_a;
            run++;
            if (on_b) done_b++;
            else done_a++;
            // Switch sides after each run, only while the other side has bytes left
            if (run == ratio) begin
              if (!on_b && done_b < count_b) on_b = 1'b1;
              else if (on_b && done_a < count_a) on_b = 1'b0;
              run = 0;
            end
          end
        end
      endcase
      span_beats_q.push_back('{element: pick, last: (i + 1 == span_len)});
    end
  endfunction

  // Compare each output beat with the oldest expectation, then take new requests
  always @(posedge clk) begin
    if (!rst_n) begin
      span_beats_q.delete();
      errs = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (span_beats_q.size() == 0) begin
          errs++;
          $display("%0t: stray beat: expected none, actual element %h last %b",
                   $time, out_element, out_last);
        end else begin
          want = span_beats_q.pop_front();
          if (out_element !== want.element) begin
            errs++;
            $display("%0t: element mismatch: expected %h, actual %h",
                     $time, want.element, out_element);
          end
          if (out_last !== want.last) begin
            errs++;
            $display("%0t: last mismatch: expected %b, actual %b",
                     $time, want.last, out_last);
          end
        end
      end
      if (in_valid && !in_stall)
        plan_span(in_command, in_count_a, in_count_b, in_value_a, in_value_b,
                  in_total_length);
    end
    mismatches <= errs;
    beats_due  <= span_beats_q.size();
  end

endmodule

/* bench/two_value_span_sequencer_tb.sv */
// Testbench top for the two value span sequencer: clock, reset, request stimulus and verdict.
module two_value_span_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tvss_pkg::*;

  localparam int IDLE_LIMIT = 2000;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [CMD_W-1:0]  in_command;
  logic [CNT_W-1:0]  in_count_a;
  logic [CNT_W-1:0]  in_count_b;
  logic [BYTE_W-1:0] in_value_a;
  logic [BYTE_W-1:0] in_value_b;
  logic [CNT_W-1:0]  in_total_length;
  logic              out_valid;
  logic              out_stall;
  logic [BYTE_W-1:0] out_element;
  logic              out_last;
  int                mismatches;
  int                beats_due;
  int                idle_run = 0;
  bit                quiet = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  two_value_span_sequencer DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_count_a      (in_count_a),
    .in_count_b      (in_count_b),
    .in_value_a      (in_value_a),
    .in_value_b      (in_value_b),
    .in_total_length (in_total_length),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_element     (out_element),
    .out_last        (out_last)
  );

  two_value_span_sequencer_chk chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_count_a      (in_count_a),
    .in_count_b      (in_count_b),
    .in_value_a      (in_value_a),
    .in_value_b      (in_value_b),
    .in_total_length (in_total_length),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_element     (out_element),
    .out_last        (out_last),
    .mismatches      (mismatches),
    .beats_due       (beats_due)
  );

  // Stall the output in random bursts, never back to back, and not at all once quiet is set
  initial begin
    int stall_left;
    stall_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0 && !quiet) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        stall_left = 0;
        if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 10);
      end
    end
  end

  // Count cycles in which no beat moves on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_run <= 0;
    else idle_run <= idle_run + 1;
  end

  initial begin
    wait (idle_run >= IDLE_LIMIT);
    $display("status: fail");
    $finish;
  end

  // Drive one request, hold it until taken, then maybe leave a gap
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [CNT_W-1:0] ca,
                              input logic [CNT_W-1:0] cb, input logic [BYTE_W-1:0] va,
                              input logic [BYTE_W-1:0] vb, input logic [CNT_W-1:0] len);
    @(negedge clk);
    in_command      <= cmd;
    in_count_a      <= ca;
    in_count_b      <= cb;
    in_value_a      <= va;
    in_value_b      <= vb;
    in_total_length <= len;
    in_valid        <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 10)) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
  endtask

  initial begin
    int               good_sent;
    logic [CNT_W-1:0] len;
    logic [CNT_W-1:0] ca;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_command      = CMD_A_FIRST;
    in_count_a      = '0;
    in_count_b      = '0;
    in_value_a      = '0;
    in_value_b      = '0;
    in_total_length = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: each mode, ratio shapes, count extremes and rejected requests
    send_request(CMD_A_FIRST, 7'd3, 7'd2, 8'h00, 8'hFF, 7'd5);
    send_request(CMD_B_FIRST, 7'd3, 7'd2, 8'hFF, 8'h00, 7'd5);
    send_request(CMD_EVEN, 7'd2, 7'd5, 8'h11, 8'h22, 7'd7);
    send_request(CMD_EVEN, 7'd5, 7'd2, 8'h33, 8'h44, 7'd7);
    send_request(CMD_EVEN, 7'd4, 7'd4, 8'hAA, 8'h55, 7'd8);
    send_request(CMD_EVEN, 7'd0, 7'd7, 8'h01, 8'h80, 7'd7);
    send_request(CMD_EVEN, 7'd7, 7'd0, 8'h7F, 8'hFE, 7'd7);
    send_request(CMD_EVEN, 7'd1, 7'd63, 8'hC3, 8'h3C, 7'd64);
    send_request(CMD_EVEN, 7'd63, 7'd1, 8'h3C, 8'hC3, 7'd64);
    send_request(CMD_A_FIRST, 7'd64, 7'd0, 8'hFF, 8'h00, 7'd64);
    send_request(CMD_B_FIRST, 7'd0, 7'd64, 8'h00, 8'hFF, 7'd64);
    send_request(CMD_A_FIRST, 7'd0, 7'd64, 8'h5A, 8'hA5, 7'd64);
    send_request(CMD_EVEN, 7'd32, 7'd32, 8'h12, 8'h34, 7'd64);
    send_request(CMD_EVEN, 7'd7, 7'd3, 8'h56, 8'h78, 7'd10);
    send_request(CMD_EVEN, 7'd3, 7'd10, 8'h9A, 8'hBC, 7'd13);
    send_request(CMD_A_FIRST, 7'd1, 7'd0, 8'hDE, 8'hAD, 7'd1);
    send_request(CMD_B_FIRST, 7'd1, 7'd1, 8'hA5, 8'h5A, 7'd2);
    // Counts that do not add up, including a sum past the field width
    send_request(CMD_A_FIRST, 7'd3, 7'd3, 8'h01, 8'h02, 7'd5);
    send_request(CMD_EVEN, 7'd64, 7'd64, 8'h03, 8'h04, 7'd0);
    send_request(CMD_B_FIRST, 7'd127, 7'd127, 8'hFF, 8'hFF, 7'd127);
    // Length past the limit, spare command code, zero length
    send_request(CMD_A_FIRST, 7'd65, 7'd0, 8'h05, 8'h06, 7'd65);
    send_request(CMD_EVEN, 7'd100, 7'd27, 8'h07, 8'h08, 7'd127);
    send_request(CMD_RSVD, 7'd2, 7'd2, 8'h09, 8'h0A, 7'd4);
    send_request(CMD_A_FIRST, 7'd0, 7'd0, 8'h0B, 8'h0C, 7'd0);
    send_request(CMD_EVEN, 7'd0, 7'd0, 8'h0D, 8'h0E, 7'd0);

    // Random: mostly consistent requests with short runs, some noise
    good_sent = 0;
    while (good_sent < 240) begin
      if (good_sent >= 200) quiet = 1'b1;
      if ($urandom_range(0, 6) == 0) begin
        send_request(CMD_W'($urandom_range(0, 3)), CNT_W'($urandom), CNT_W'($urandom),
                     BYTE_W'($urandom), BYTE_W'($urandom), CNT_W'($urandom));
      end else begin
        len = ($urandom_range(0, 7) == 0) ? CNT_W'($urandom_range(17, 64))
                                          : CNT_W'($urandom_range(1, 16));
        ca  = CNT_W'($urandom_range(0, len));
        send_request(CMD_W'($urandom_range(0, 2)), ca, len - ca,
                     BYTE_W'($urandom), BYTE_W'($urandom), len);
        good_sent++;
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;

    // Drain the expected beats, then let any late stray beat show up
    while (beats_due != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
